/* hw/rtl/lcdnf_pkg.sv */
// Shared types and constants for the character-LCD number formatter.
// Used by the controller, the datapath and the top level; no dependencies.
package lcdnf_pkg;

	// Request function codes
	localparam logic [2:0] FN_CHAR = 3'd0;
	localparam logic [2:0] FN_UDEC = 3'd1;
	localparam logic [2:0] FN_SDEC = 3'd2;
	localparam logic [2:0] FN_HEX  = 3'd3;
	localparam logic [2:0] FN_BIN  = 3'd4;

	// LCD bytes and character codes
	localparam logic [7:0] LCD_SET_ADDR = 8'h80;
	localparam logic [7:0] LINE2_OFFSET = 8'h40;
	localparam logic [7:0] CHR_ZERO     = 8'h30;
	localparam logic [7:0] CHR_PLUS     = 8'h2B;
	localparam logic [7:0] CHR_MINUS    = 8'h2D;
	localparam logic [7:0] CHR_HEX_BASE = 8'h37;  // 'A' minus ten

	// Digit-position limits of a 16-bit value per radix
	localparam logic [3:0] DEC_POSITIONS = 4'd5;
	localparam logic [3:0] HEX_POSITIONS = 4'd4;

	// Double-dabble conversion: one source bit per cycle, five BCD digits
	localparam int unsigned BCD_DIGITS = 5;
	localparam int unsigned BCD_W      = 4 * BCD_DIGITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_CMD,
		ST_CHAR,
		ST_SIGN,
		ST_DIGIT
	} ctl_state_t;

	typedef enum logic [1:0] {
		SEL_CMD,
		SEL_CHAR,
		SEL_SIGN,
		SEL_DIGIT
	} byte_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic      load;
		logic      conv_step;
		logic      emit;
		byte_sel_t sel;
		logic      last;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [2:0] func;
		logic       cnt_zero;
		logic       cnt_one;
		logic       conv_done;
		logic       out_free;
	} dp_status_t;

endpackage

/* hw/rtl/lcdnf_req_if.sv */
// Request channel: valid/ready handshake carrying one display request word.
// Standalone interface; no dependencies.
interface lcdnf_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [1:0]  row;
	logic [5:0]  col;
	logic [15:0] value;
	logic [4:0]  digit_count;

	modport source (output valid, func, row, col, value, digit_count, input ready);
	modport sink   (input valid, func, row, col, value, digit_count, output ready);
endinterface

/* hw/rtl/lcdnf_byte_if.sv */
// Output channel: valid/ready handshake carrying one LCD bus byte per word.
// Standalone interface; no dependencies.
interface lcdnf_byte_if;
	logic       valid;
	logic       ready;
	logic       is_data;
	logic [7:0] lcd_byte;
	logic       last;

	modport source (output valid, is_data, lcd_byte, last, input ready);
	modport sink   (input valid, is_data, lcd_byte, last, output ready);
endinterface

/* hw/rtl/lcdnf_datapath.sv */
// Datapath: request registers, BCD converter, digit selection and output register.
// Depends on lcdnf_pkg.
module lcdnf_datapath #(
	parameter int unsigned MAX_DIGITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lcdnf_pkg::ctl_cmd_t     cmd,
	output lcdnf_pkg::dp_status_t   sts,
	input  logic [2:0]              func,
	input  logic [1:0]              row,
	input  logic [5:0]              col,
	input  logic [15:0]             value,
	input  logic [4:0]              digit_count,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    out_is_data,
	output logic [7:0]              out_byte,
	output logic                    out_last
);
	import lcdnf_pkg::*;

	localparam logic [4:0] MAX_CNT = 5'(MAX_DIGITS);

	logic [2:0]       func_q;
	logic [7:0]       cmd_byte_q;
	logic [7:0]       char_q;
	logic             neg_q;
	logic [15:0]      mag_q;
	logic [4:0]       dcnt_q;
	logic [15:0]      conv_q;
	logic [BCD_W-1:0] bcd_q;
	logic [3:0]       conv_cnt_q;
	logic             out_valid_q;
	logic             out_is_data_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic [7:0]       addr;
	logic [4:0]       cnt_sat;
	logic [15:0]      mag_in;
	logic [BCD_W-1:0] bcd_adj;
	logic [3:0]       pos;
	logic [3:0]       dec_nib;
	logic [3:0]       hex_nib;
	logic [7:0]       digit_char;
	logic [7:0]       sel_byte;
	logic             out_free;

	// Set-address command and saturated digit count, taken from the request.
	always_comb begin
		addr = 8'(col) + 8'hFF + ((row == 2'd1) ? 8'h00 : LINE2_OFFSET);
		cnt_sat = (digit_count > MAX_CNT) ? MAX_CNT : digit_count;
		mag_in = (func == FN_SDEC && value[15]) ? (16'd0 - value) : value;
	end

	// Request registers and remaining digit count.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			cmd_byte_q <= LCD_SET_ADDR | addr;
			char_q <= value[7:0];
			neg_q <= value[15];
			mag_q <= mag_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.load) begin
			dcnt_q <= cnt_sat;
		end else if (cmd.emit && cmd.sel == SEL_DIGIT) begin
			dcnt_q <= dcnt_q - 5'd1;
		end
	end

	// Double-dabble step: add three to each digit of five or more, then shift in a bit.
	always_comb begin
		for (int k = 0; k < BCD_DIGITS; k++) begin
			bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
				: bcd_q[4*k +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_cnt_q <= '0;
		end else if (cmd.load) begin
			conv_cnt_q <= '0;
		end else if (cmd.conv_step) begin
			conv_cnt_q <= conv_cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			conv_q <= mag_in;
			bcd_q <= '0;
		end else if (cmd.conv_step) begin
			conv_q <= {conv_q[14:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], conv_q[15]};
		end
	end

	// Character for the current digit position, most significant first.
	always_comb begin
		pos = dcnt_q[3:0] - 4'd1;
		case (pos[2:0])
			3'd0:    dec_nib = bcd_q[3:0];
			3'd1:    dec_nib = bcd_q[7:4];
			3'd2:    dec_nib = bcd_q[11:8];
			3'd3:    dec_nib = bcd_q[15:12];
			3'd4:    dec_nib = bcd_q[19:16];
			default: dec_nib = 4'd0;
		endcase
		hex_nib = mag_q[{pos[1:0], 2'b00} +: 4];
		case (func_q)
			FN_HEX: begin
				if (pos >= HEX_POSITIONS) begin
					digit_char = CHR_ZERO;
				end else if (hex_nib < 4'd10) begin
					digit_char = CHR_ZERO + 8'(hex_nib);
				end else begin
					digit_char = CHR_HEX_BASE + 8'(hex_nib);
				end
			end
			FN_BIN: begin
				digit_char = CHR_ZERO + 8'(mag_q[pos]);
			end
			default: begin
				digit_char = (pos >= DEC_POSITIONS) ? CHR_ZERO : CHR_ZERO + 8'(dec_nib);
			end
		endcase
	end

	// Byte selection for the output register.
	always_comb begin
		case (cmd.sel)
			SEL_CMD:   sel_byte = cmd_byte_q;
			SEL_CHAR:  sel_byte = char_q;
			SEL_SIGN:  sel_byte = neg_q ? CHR_MINUS : CHR_PLUS;
			SEL_DIGIT: sel_byte = digit_char;
			default:   sel_byte = cmd_byte_q;
		endcase
	end

	// Output register; it frees up in the cycle its word is taken.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_is_data_q <= (cmd.sel != SEL_CMD);
			out_byte_q <= sel_byte;
			out_last_q <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_is_data = out_is_data_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

	always_comb begin
		sts.func = func_q;
		sts.cnt_zero = (dcnt_q == 5'd0);
		sts.cnt_one = (dcnt_q == 5'd1);
		sts.conv_done = (conv_cnt_q == 4'hF);
		sts.out_free = out_free;
	end

	// A word is never loaded over one that is still waiting.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("word emitted while output register is occupied");

	// The digit count never underflows.
	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.sel == SEL_DIGIT) |-> dcnt_q != 5'd0)
		else $error("digit emitted with no digits left");

	// An emitted word appears on the output in the next cycle with its last flag.
	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (out_valid_q && out_last_q == $past(cmd.last)))
		else $error("emitted word missing from output register");

endmodule

/* hw/rtl/lcdnf_ctrl.sv */
// Controller state machine: sequences conversion, command byte, character, sign and digits.
// Depends on lcdnf_pkg.
module lcdnf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            in_func,
	input  lcdnf_pkg::dp_status_t sts,
	output lcdnf_pkg::ctl_cmd_t   cmd
);
	import lcdnf_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic       numeric;

	assign numeric = (sts.func == FN_UDEC) || (sts.func == FN_HEX) || (sts.func == FN_BIN);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_func == FN_UDEC || in_func == FN_SDEC) ? ST_CONV : ST_CMD;
				end
			end
			ST_CONV: begin
				if (sts.conv_done) begin
					state_d = ST_CMD;
				end
			end
			ST_CMD: begin
				if (sts.out_free) begin
					if (sts.func == FN_CHAR) begin
						state_d = ST_CHAR;
					end else if (sts.func == FN_SDEC) begin
						state_d = ST_SIGN;
					end else if (numeric && !sts.cnt_zero) begin
						state_d = ST_DIGIT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CHAR: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SIGN: begin
				if (sts.out_free) begin
					state_d = sts.cnt_zero ? ST_IDLE : ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (sts.out_free && sts.cnt_one) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready = 1'b0;
		cmd.load = 1'b0;
		cmd.conv_step = 1'b0;
		cmd.emit = 1'b0;
		cmd.sel = SEL_CMD;
		cmd.last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
			end
			ST_CMD: begin
				cmd.emit = sts.out_free;
				cmd.sel = SEL_CMD;
				cmd.last = !((sts.func == FN_CHAR) || (sts.func == FN_SDEC)
					|| (numeric && !sts.cnt_zero));
			end
			ST_CHAR: begin
				cmd.emit = sts.out_free;
				cmd.sel = SEL_CHAR;
				cmd.last = 1'b1;
			end
			ST_SIGN: begin
				cmd.emit = sts.out_free;
				cmd.sel = SEL_SIGN;
				cmd.last = sts.cnt_zero;
			end
			ST_DIGIT: begin
				cmd.emit = sts.out_free;
				cmd.sel = SEL_DIGIT;
				cmd.last = sts.cnt_one;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// A decimal request always runs its conversion before the command byte.
	a_conv_first: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && (in_func == FN_UDEC || in_func == FN_SDEC)) |=> state_q == ST_CONV)
		else $error("decimal request skipped conversion");

	// The digit state is only entered with digits remaining.
	a_digit_state: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIGIT |-> !sts.cnt_zero)
		else $error("digit state with zero digits left");

	// The last word of a request returns the controller to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> state_q == ST_IDLE)
		else $error("controller busy after last word");

endmodule

/* hw/rtl/char_lcd_number_formatter.sv */
// Top level of the character-LCD number formatter.
// Depends on lcdnf_pkg, lcdnf_req_if, lcdnf_byte_if, lcdnf_ctrl and lcdnf_datapath.
//
//   Channel  Dir  Word
//   req      in   func, row, col, value, digit_count
//   lcd      out  is_data, lcd_byte, last (one LCD bus byte)
//
// One request gives one command byte and up to 17 data bytes, one per cycle while
// the output is taken. Decimal requests first pass through the bit-serial BCD
// converter; char, hex, binary and undefined codes go straight to the command byte.
// The next request is accepted in the cycle after the last byte is loaded.
// A stalled output holds the sequence in place. Reset clears the controller, the
// counters and the output valid flag.
module char_lcd_number_formatter #(
	parameter int unsigned MAX_DIGITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	lcdnf_req_if.sink     req,
	lcdnf_byte_if.source  lcd
);
	import lcdnf_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t sts;

	// Sequencing of each request.
	lcdnf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_func  (req.func),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Storage, conversion and byte generation.
	lcdnf_datapath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (req.func),
		.row         (req.row),
		.col         (req.col),
		.value       (req.value),
		.digit_count (req.digit_count),
		.out_valid   (lcd.valid),
		.out_ready   (lcd.ready),
		.out_is_data (lcd.is_data),
		.out_byte    (lcd.lcd_byte),
		.out_last    (lcd.last)
	);

endmodule
